@@ design/http_response_header_parser_defines.svh @@
// Assertion macros shared by the HTTP response header parser RTL.
// Depends on nothing; included by the top level that carries the checks.
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRHP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRHP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hrhp_pkg.sv @@
// Types, codes and constants of the HTTP response header parser.
// Depends on nothing; used by every module of the parser.
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

    typedef enum logic [4:0] {
        PH_H1,
        PH_T1,
        PH_T2,
        PH_P1,
        PH_SL,
        PH_MAJ,
        PH_DOT,
        PH_MIN,
        PH_CWS,
        PH_CNUM,
        PH_PHR,
        PH_SLF,
        PH_KEY,
        PH_PRECOLON,
        PH_VAL,
        PH_HLF,
        PH_FLF,
        PH_BODY,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FRAMING,
        KIND_PHRASE,
        KIND_NAME,
        KIND_VALUE,
        KIND_LINE_END,
        KIND_HDR_DONE,
        KIND_BODY
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_MISMATCH,
        ERR_NOT_NUMERIC,
        ERR_EMPTY_PHRASE,
        ERR_NO_COLON,
        ERR_NO_CRLF,
        ERR_TRUNCATED
    } err_code_t;

    // Parser state carried from one beat to the next.
    typedef struct packed {
        phase_t      phase;
        logic [31:0] code_acc;       // code magnitude, capped at 2^31
        logic        code_negative;
        logic        field_nonempty;
        err_code_t   error;
        logic        code_done;
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        kind_t              kind;
        logic signed [31:0] status_code;
        logic               code_valid;
        err_code_t          error;
        logic               last;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_H1,
        code_acc:       32'd0,
        code_negative:  1'b0,
        field_nonempty: 1'b0,
        error:          ERR_NONE,
        code_done:      1'b0
    };

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [31:0] CODE_CAP = 32'h8000_0000;
    localparam logic [31:0] CODE_MAX = 32'h7FFF_FFFF;

    // Space, tab, LF, VT, FF and CR.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Expected byte of the protocol literal for the first five phases.
    function automatic logic [7:0] lit_char(input phase_t ph);
        logic [7:0] ch;
        unique case (ph)
            PH_H1:   ch = 8'h48; // H
            PH_T1:   ch = 8'h54; // T
            PH_T2:   ch = 8'h54; // T
            PH_P1:   ch = 8'h50; // P
            PH_SL:   ch = 8'h2F; // slash
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ design/http_response_header_parser.sv @@
// Top level of the HTTP response header parser: ports, state and result register.
// Depends on hrhp_pkg, hrhp_in_reg, hrhp_step and the assertion macro header.
//
// Usage: the response buffer enters one byte per beat on the s_ channel, with
// s_tlast high on the final byte of the buffer. Every input beat yields exactly
// one result beat on the m_ channel: the byte echoed with a tag (m_tuser) that
// says whether it is framing, reason phrase, header name, header value, a
// header line end, the end of the header section, or body. The result also
// carries the status code read so far (saturated to 32 bits), a flag that the
// code digits have ended, and an error code. After an error every byte up to
// the one flagged last is tagged framing and carries that error.
// An accepted beat goes through the input register, then the result register,
// to m_. The block sustains one byte per cycle while m_tready is high: the
// input register feeds one pass of per-byte logic into the result register,
// and the parser state loop closes through the state register alone. When the
// receiver holds m_tready low the result register keeps its beat, the input
// register still takes one more byte, and only then does s_tready fall. A beat
// flagged last returns the parser to the start of a new response. Synchronous
// active-low reset empties both registers and puts the parser at a response start.
`timescale 1ns / 1ps
`default_nettype none

`include "http_response_header_parser_defines.svh"

module http_response_header_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] byte_out, [39:8] status_code,
                                        // [40] code_valid, [43:41] error, [47:44] zero
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast
);

    logic               in_valid;
    hrhp_pkg::in_beat_t in_beat;
    logic               advance;

    hrhp_pkg::state_t   state_reg;
    hrhp_pkg::state_t   state_next;
    hrhp_pkg::state_t   step_state;
    hrhp_pkg::result_t  step_res;

    logic               m_valid_reg;
    hrhp_pkg::result_t  m_res_reg;

    // A byte moves from the input register into the result register whenever
    // the result register is empty or its beat is being taken this cycle.
    assign advance = in_valid && (!m_valid_reg || m_tready);

    hrhp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .q_valid  (in_valid),
        .q_beat   (in_beat)
    );

    hrhp_step u_step (
        .cur  (state_reg),
        .beat (in_beat),
        .nxt  (step_state),
        .res  (step_res)
    );

    // The last byte of a buffer restarts the parser for the next response.
    always_comb begin
        if (in_beat.last) begin
            state_next = hrhp_pkg::STATE_RESET;
        end else begin
            state_next = step_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hrhp_pkg::STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_res_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_res_reg.error, m_res_reg.code_valid,
                       m_res_reg.status_code, m_res_reg.data_byte};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;

    // A byte flagged last leaves the parser at the start of a fresh response.
    `HRHP_ASSERT_NEXT(a_last_restarts, aclk, aresetn, advance && in_beat.last, state_reg.phase == hrhp_pkg::PH_H1 && !state_reg.code_done && state_reg.error == hrhp_pkg::ERR_NONE, "parser did not restart after last byte")

    // A tagged byte can only carry no error, or the truncation report.
    `HRHP_ASSERT_NOW(a_tag_no_error, aclk, aresetn, m_valid_reg && m_res_reg.kind != hrhp_pkg::KIND_FRAMING, m_res_reg.error == hrhp_pkg::ERR_NONE || m_res_reg.error == hrhp_pkg::ERR_TRUNCATED, "tagged byte carries a latched error")

    // Body bytes only follow a completed status code.
    `HRHP_ASSERT_NOW(a_body_has_code, aclk, aresetn, m_valid_reg && m_res_reg.kind == hrhp_pkg::KIND_BODY, m_res_reg.code_valid, "body byte without a finished status code")

    // With the result register empty, the input side never stalls.
    `HRHP_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_tready, "input stalled while result register empty")

endmodule

`default_nettype wire

@@ design/hrhp_in_reg.sv @@
// Input register stage of the HTTP response header parser.
// Depends on hrhp_pkg for the beat type.
`timescale 1ns / 1ps
`default_nettype none

module hrhp_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              advance,
    output logic                   q_valid,
    output hrhp_pkg::in_beat_t     q_beat
);

    logic               valid_reg;
    hrhp_pkg::in_beat_t beat_reg;

    // The stage can take a new beat when empty or when its beat moves on.
    assign s_tready = !valid_reg || advance;
    assign q_valid  = valid_reg;
    assign q_beat   = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg.data_byte <= s_tdata;
            beat_reg.last      <= s_tlast;
        end
    end

endmodule

`default_nettype wire

@@ design/hrhp_step.sv @@
// Per-byte parser logic: next state and tagged result for one beat.
// Depends on hrhp_pkg for state, result types and character constants.
`timescale 1ns / 1ps
`default_nettype none

module hrhp_step (
    input  wire hrhp_pkg::state_t   cur,
    input  wire hrhp_pkg::in_beat_t beat,
    output hrhp_pkg::state_t        nxt,
    output hrhp_pkg::result_t       res
);

    logic [7:0]  c;
    logic        c_ws;
    logic        c_digit;
    logic [3:0]  digit;
    logic [35:0] acc_x10;
    logic [31:0] acc_sat;
    logic        name_end;

    function automatic hrhp_pkg::state_t fail_st(input hrhp_pkg::state_t st,
                                                 input hrhp_pkg::err_code_t code);
        hrhp_pkg::state_t r;
        r       = st;
        r.phase = hrhp_pkg::PH_ERR;
        r.error = code;
        return r;
    endfunction

    assign c        = beat.data_byte;
    assign c_ws     = hrhp_pkg::is_ws(c);
    assign c_digit  = (c >= hrhp_pkg::CH_ZERO) && (c <= hrhp_pkg::CH_NINE);
    assign digit    = 4'(c - hrhp_pkg::CH_ZERO);
    assign name_end = (c == hrhp_pkg::CH_COLON) || (c == hrhp_pkg::CH_SPACE) ||
                      (c == hrhp_pkg::CH_CR) || (c == hrhp_pkg::CH_NUL);

    // acc * 10 + digit as two shifts and adds, then clamp at 2^31.
    assign acc_x10 = ({4'd0, cur.code_acc} << 3) + ({4'd0, cur.code_acc} << 1) +
                     {32'd0, digit};
    assign acc_sat = (acc_x10 > {4'd0, hrhp_pkg::CODE_CAP}) ? hrhp_pkg::CODE_CAP
                                                           : acc_x10[31:0];

    // Next state.
    always_comb begin
        nxt = cur;
        unique case (cur.phase)
            hrhp_pkg::PH_H1, hrhp_pkg::PH_T1, hrhp_pkg::PH_T2,
            hrhp_pkg::PH_P1, hrhp_pkg::PH_SL: begin
                if (c == hrhp_pkg::lit_char(cur.phase)) begin
                    nxt.phase = hrhp_pkg::phase_t'(cur.phase + 5'd1);
                end else begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_MISMATCH);
                end
            end
            hrhp_pkg::PH_MAJ: nxt.phase = hrhp_pkg::PH_DOT;
            hrhp_pkg::PH_DOT: begin
                if (c == hrhp_pkg::CH_DOT) begin
                    nxt.phase = hrhp_pkg::PH_MIN;
                end else begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_MISMATCH);
                end
            end
            hrhp_pkg::PH_MIN: nxt.phase = hrhp_pkg::PH_CWS;
            hrhp_pkg::PH_CWS: begin
                priority if (c_ws) begin
                    nxt = cur;
                end else if (c == hrhp_pkg::CH_PLUS || c == hrhp_pkg::CH_MINUS) begin
                    nxt.code_negative  = (c == hrhp_pkg::CH_MINUS);
                    nxt.field_nonempty = 1'b0;
                    nxt.phase          = hrhp_pkg::PH_CNUM;
                end else if (c_digit) begin
                    nxt.code_acc       = {28'd0, digit};
                    nxt.field_nonempty = 1'b1;
                    nxt.phase          = hrhp_pkg::PH_CNUM;
                end else begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_NOT_NUMERIC);
                end
            end
            hrhp_pkg::PH_CNUM: begin
                priority if (c_digit) begin
                    nxt.code_acc       = acc_sat;
                    nxt.field_nonempty = 1'b1;
                end else if (!cur.field_nonempty) begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_NOT_NUMERIC);
                end else begin
                    // The byte that ends the digits, unless whitespace, is the first phrase byte.
                    nxt.code_done      = 1'b1;
                    nxt.field_nonempty = 1'b0;
                    nxt.phase          = hrhp_pkg::PH_PHR;
                    if (c == hrhp_pkg::CH_CR) begin
                        nxt = fail_st(nxt, hrhp_pkg::ERR_EMPTY_PHRASE);
                    end else if (!c_ws) begin
                        nxt.field_nonempty = 1'b1;
                    end
                end
            end
            hrhp_pkg::PH_PHR: begin
                priority if (c == hrhp_pkg::CH_CR) begin
                    if (!cur.field_nonempty) begin
                        nxt = fail_st(cur, hrhp_pkg::ERR_EMPTY_PHRASE);
                    end else begin
                        nxt.phase = hrhp_pkg::PH_SLF;
                    end
                end else if (c_ws && !cur.field_nonempty) begin
                    nxt = cur;
                end else begin
                    nxt.field_nonempty = 1'b1;
                end
            end
            hrhp_pkg::PH_SLF: begin
                if (c == hrhp_pkg::CH_LF) begin
                    nxt.phase          = hrhp_pkg::PH_KEY;
                    nxt.field_nonempty = 1'b0;
                end else begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_MISMATCH);
                end
            end
            hrhp_pkg::PH_KEY: begin
                if (name_end) begin
                    priority if (!cur.field_nonempty) begin
                        if (c == hrhp_pkg::CH_CR) begin
                            nxt.phase = hrhp_pkg::PH_FLF;
                        end else begin
                            nxt = fail_st(cur, hrhp_pkg::ERR_MISMATCH);
                        end
                    end else if (c == hrhp_pkg::CH_COLON) begin
                        nxt.phase          = hrhp_pkg::PH_VAL;
                        nxt.field_nonempty = 1'b0;
                    end else begin
                        nxt.phase = hrhp_pkg::PH_PRECOLON;
                    end
                end else begin
                    nxt.field_nonempty = 1'b1;
                end
            end
            hrhp_pkg::PH_PRECOLON: begin
                priority if (c == hrhp_pkg::CH_COLON) begin
                    nxt.phase          = hrhp_pkg::PH_VAL;
                    nxt.field_nonempty = 1'b0;
                end else if (!c_ws) begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_NO_COLON);
                end else begin
                    nxt = cur;
                end
            end
            hrhp_pkg::PH_VAL: begin
                priority if (c == hrhp_pkg::CH_CR) begin
                    nxt.phase = hrhp_pkg::PH_HLF;
                end else if (c == hrhp_pkg::CH_SPACE && !cur.field_nonempty) begin
                    nxt = cur;
                end else begin
                    nxt.field_nonempty = 1'b1;
                end
            end
            hrhp_pkg::PH_HLF: begin
                if (c == hrhp_pkg::CH_LF) begin
                    nxt.phase          = hrhp_pkg::PH_KEY;
                    nxt.field_nonempty = 1'b0;
                end else begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_NO_CRLF);
                end
            end
            hrhp_pkg::PH_FLF: begin
                if (c == hrhp_pkg::CH_LF) begin
                    nxt.phase = hrhp_pkg::PH_BODY;
                end else begin
                    nxt = fail_st(cur, hrhp_pkg::ERR_MISMATCH);
                end
            end
            hrhp_pkg::PH_BODY, hrhp_pkg::PH_ERR: nxt = cur;
            default: nxt.phase = hrhp_pkg::PH_ERR;
        endcase
    end

    // Result tagging.
    always_comb begin
        res.data_byte = c;
        res.kind      = hrhp_pkg::KIND_FRAMING;
        unique case (cur.phase)
            hrhp_pkg::PH_CNUM: begin
                if (!c_digit && cur.field_nonempty && !c_ws) begin
                    res.kind = hrhp_pkg::KIND_PHRASE;
                end
            end
            hrhp_pkg::PH_PHR: begin
                if (c != hrhp_pkg::CH_CR && !(c_ws && !cur.field_nonempty)) begin
                    res.kind = hrhp_pkg::KIND_PHRASE;
                end
            end
            hrhp_pkg::PH_KEY: begin
                if (!name_end) begin
                    res.kind = hrhp_pkg::KIND_NAME;
                end else if (!cur.field_nonempty && c == hrhp_pkg::CH_CR) begin
                    res.kind = hrhp_pkg::KIND_HDR_DONE;
                end
            end
            hrhp_pkg::PH_VAL: begin
                if (c == hrhp_pkg::CH_CR) begin
                    res.kind = hrhp_pkg::KIND_LINE_END;
                end else if (!(c == hrhp_pkg::CH_SPACE && !cur.field_nonempty)) begin
                    res.kind = hrhp_pkg::KIND_VALUE;
                end
            end
            hrhp_pkg::PH_HLF: begin
                if (c == hrhp_pkg::CH_LF) begin
                    res.kind = hrhp_pkg::KIND_LINE_END;
                end
            end
            hrhp_pkg::PH_FLF: begin
                if (c == hrhp_pkg::CH_LF) begin
                    res.kind = hrhp_pkg::KIND_HDR_DONE;
                end
            end
            hrhp_pkg::PH_BODY: res.kind = hrhp_pkg::KIND_BODY;
            default: res.kind = hrhp_pkg::KIND_FRAMING;
        endcase

        if (nxt.code_negative) begin
            res.status_code = 32'd0 - nxt.code_acc;
        end else if (nxt.code_acc[31]) begin
            res.status_code = hrhp_pkg::CODE_MAX;
        end else begin
            res.status_code = nxt.code_acc;
        end

        res.code_valid = nxt.code_done;
        if (beat.last && nxt.error == hrhp_pkg::ERR_NONE &&
            nxt.phase != hrhp_pkg::PH_BODY) begin
            res.error = hrhp_pkg::ERR_TRUNCATED;
        end else begin
            res.error = nxt.error;
        end
        res.last = beat.last;
    end

endmodule

`default_nettype wire
